@@ rtl/core/ffsa_pkg.sv @@
package ffsa_pkg;

    localparam int START_W     = 12;
    localparam int SIZE_W      = 13;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int MIN_REMAIN  = 16;
    localparam int WORD_BYTES  = 8;
    localparam int BASE_START  = 8;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_NOFIT = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FREE_SHIFT,
        ST_FREE_PUT,
        ST_SCAN,
        ST_SPLIT,
        ST_REMOVE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [START_W-1:0] start;
    } t_seg;

endpackage

@@ rtl/core/ffsa_ram.sv @@
module ffsa_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/first_fit_segment_allocator.sv @@
// Channel   Direction  tuser              tdata
// s_axis    in         kind               offset, size_bytes
// m_axis    out        status             grant_offset, grant_bytes
//
// Free: every table entry is moved up one place, then the freed segment is written at entry 0;
// a free into a full table is dropped. Allocate: entries are scanned in order, one table read
// per cycle, then a split segment is shrunk or the later entries are moved down on removal.
// After reset the init state writes the initial segment before the first request is taken.
// A waiting result stalls only the next request's finish, not its acceptance.
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // offset[11:0], size_bytes[24:12]
    input  logic                   s_axis_tuser,  // kind[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // grant_offset[11:0], grant_bytes[24:12]
    output logic [1:0]             m_axis_tuser   // status[1:0]
);

    localparam int IW      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW      = $clog2(MAX_SEGMENTS + 1);
    localparam int HeapRem = HEAP_BYTES - BASE_START;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_ptr, n_ptr;
    logic [START_W-1:0]  r_off;
    logic [SIZE_W-1:0]   r_req;
    logic [START_W-1:0]  r_st;
    logic [SIZE_W-1:0]   r_sz;
    t_status             r_res_status, n_res_status;
    logic [START_W-1:0]  r_res_off, n_res_off;
    logic [SIZE_W-1:0]   r_res_bytes, n_res_bytes;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [START_W-1:0]  r_out_off;
    logic [SIZE_W-1:0]   r_out_bytes;

    logic                ram_we, ram_re;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    t_seg                ram_wdata, rd;
    logic                accept, full, empty, last, rm_last, fit, take_all;
    logic                res_load, seg_load, out_load;
    logic [SIZE_W:0]     diff, rnd;
    logic [SIZE_W-1:0]   grant;

    ffsa_ram #(.WIDTH($bits(t_seg)), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign full    = r_count >= CW'(MAX_SEGMENTS);
    assign empty   = r_count == '0;
    assign last    = (CW'(r_ptr) + CW'(1)) == r_count;
    assign rm_last = (CW'(r_ptr) + CW'(2)) == r_count;
    assign fit     = rd.size >= r_req;
    assign diff    = {1'b0, rd.size} - {1'b0, r_req};
    assign take_all = diff < (SIZE_W+1)'(MIN_REMAIN);
    assign rnd     = ({1'b0, r_req} + (SIZE_W+1)'(WORD_BYTES - 1))
                     & ~(SIZE_W+1)'(WORD_BYTES - 1);
    assign grant   = (rnd < (SIZE_W+1)'(2 * WORD_BYTES)) ? SIZE_W'(2 * WORD_BYTES)
                                                          : rnd[SIZE_W-1:0];
    assign out_load = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser == KIND_FREE) begin
                        if (full) n_state = ST_EMIT;
                        else if (empty) n_state = ST_FREE_PUT;
                        else n_state = ST_FREE_SHIFT;
                    end else begin
                        n_state = empty ? ST_EMIT : ST_SCAN;
                    end
                end
            end
            ST_FREE_SHIFT: if (r_ptr == '0) n_state = ST_FREE_PUT;
            ST_FREE_PUT:   n_state = ST_EMIT;
            ST_SCAN: begin
                if (fit) begin
                    if (!take_all) n_state = ST_SPLIT;
                    else n_state = last ? ST_EMIT : ST_REMOVE;
                end else if (last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_SPLIT:  n_state = ST_EMIT;
            ST_REMOVE: if (rm_last) n_state = ST_EMIT;
            ST_EMIT:   if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = rd;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        n_ptr         = r_ptr;
        n_count       = r_count;
        res_load      = 1'b0;
        seg_load      = 1'b0;
        n_res_status  = STATUS_OK;
        n_res_off     = '0;
        n_res_bytes   = '0;
        case (r_state)
            ST_INIT: begin
                ram_we          = 1'b1;
                ram_wdata.start = START_W'(BASE_START);
                ram_wdata.size  = SIZE_W'(HeapRem);
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (accept) begin
                    if (s_axis_tuser == KIND_FREE) begin
                        if (full) begin
                            res_load     = 1'b1;
                            n_res_status = STATUS_FULL;
                        end else if (!empty) begin
                            ram_re    = 1'b1;
                            ram_raddr = IW'(r_count - CW'(1));
                            n_ptr     = IW'(r_count - CW'(1));
                        end
                    end else if (empty) begin
                        res_load     = 1'b1;
                        n_res_status = STATUS_NOFIT;
                    end else begin
                        ram_re = 1'b1;
                        n_ptr  = '0;
                    end
                end
            end
            ST_FREE_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(r_ptr + 1'b1);
                if (r_ptr != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(r_ptr - 1'b1);
                    n_ptr     = IW'(r_ptr - 1'b1);
                end
            end
            ST_FREE_PUT: begin
                ram_we          = 1'b1;
                ram_wdata.start = r_off;
                ram_wdata.size  = r_req;
                n_count         = CW'(r_count + 1'b1);
                res_load        = 1'b1;
            end
            ST_SCAN: begin
                ram_re    = 1'b1;
                ram_raddr = IW'(r_ptr + 1'b1);
                if (fit) begin
                    seg_load = 1'b1;
                    if (take_all) begin
                        res_load    = 1'b1;
                        n_res_off   = rd.start;
                        n_res_bytes = rd.size;
                        if (last) n_count = CW'(r_count - 1'b1);
                    end
                end else if (last) begin
                    res_load     = 1'b1;
                    n_res_status = STATUS_NOFIT;
                end else begin
                    n_ptr = IW'(r_ptr + 1'b1);
                end
            end
            ST_SPLIT: begin
                ram_we          = 1'b1;
                ram_waddr       = r_ptr;
                ram_wdata.start = START_W'(r_st + grant[START_W-1:0]);
                ram_wdata.size  = SIZE_W'(r_sz - grant);
                res_load        = 1'b1;
                n_res_off       = r_st;
                n_res_bytes     = grant;
            end
            ST_REMOVE: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                if (rm_last) begin
                    n_count = CW'(r_count - 1'b1);
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(r_ptr + 2'd2);
                    n_ptr     = IW'(r_ptr + 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_count     <= CW'(1);
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            if (out_load) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_off <= s_axis_tdata[START_W-1:0];
            r_req <= s_axis_tdata[START_W+SIZE_W-1:START_W];
        end
        if (seg_load) begin
            r_st <= rd.start;
            r_sz <= rd.size;
        end
        if (res_load) begin
            r_res_status <= n_res_status;
            r_res_off    <= n_res_off;
            r_res_bytes  <= n_res_bytes;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_off    <= r_res_off;
            r_out_bytes  <= r_res_bytes;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(OUT_TDATA_W - START_W - SIZE_W)'(0), r_out_bytes, r_out_off};

endmodule

@@ rtl/core/ffsa_checker.sv @@
module ffsa_checker
    import ffsa_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_NOFIT ||
                           m_axis_tuser == STATUS_FULL))
        else $error("illegal status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata == '0)
        else $error("failed request carries a grant");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (.*);

@@ tb/tb.sv @@
module tb;
    import ffsa_pkg::*;

    localparam int HEAP = 4096;
    localparam int SEGS = 16;

    typedef struct {
        t_status            status;
        logic [START_W-1:0] offset;
        logic [SIZE_W-1:0]  bytes;
    } t_grant;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // offset[11:0], size_bytes[24:12]
    logic                   s_axis_tuser;   // kind[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // grant_offset[11:0], grant_bytes[24:12]
    logic [1:0]             m_axis_tuser;   // status[1:0]

    logic [START_W-1:0] free_start [SEGS];
    logic [SIZE_W-1:0]  free_size  [SEGS];
    int                 free_count;

    t_grant pending_grants[$];
    t_seg   live_segs[$];
    t_grant got;
    int     n_fail;
    int     stall_left;
    logic   steady_flow;

    first_fit_segment_allocator #(
        .HEAP_BYTES  (HEAP),
        .MAX_SEGMENTS(SEGS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_cycles();
        int r;
        if (steady_flow) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_grant apply_request(t_kind k, logic [START_W-1:0] off,
                                             logic [SIZE_W-1:0] req);
        t_grant g;
        int     words;
        int     grant;
        g.status = STATUS_NOFIT;
        g.offset = '0;
        g.bytes  = '0;
        if (k == KIND_FREE) begin
            if (free_count >= SEGS) begin
                g.status = STATUS_FULL;
                return g;
            end
            for (int j = free_count; j > 0; j--) begin
                free_start[j] = free_start[j-1];
                free_size[j]  = free_size[j-1];
            end
            free_start[0] = off;
            free_size[0]  = req;
            free_count++;
            g.status = STATUS_OK;
            return g;
        end
        for (int i = 0; i < free_count; i++) begin
            if (free_size[i] >= req) begin
                g.status = STATUS_OK;
                g.offset = free_start[i];
                if (int'(free_size[i]) - int'(req) < MIN_REMAIN) begin
                    g.bytes = free_size[i];
                    for (int j = i; j + 1 < free_count; j++) begin
                        free_start[j] = free_start[j+1];
                        free_size[j]  = free_size[j+1];
                    end
                    free_count--;
                end else begin
                    words = (int'(req) + WORD_BYTES - 1) / WORD_BYTES;
                    if (words < 2) begin
                        words = 2;
                    end
                    grant = words * WORD_BYTES;
                    free_start[i] = 12'(int'(free_start[i]) + grant);
                    free_size[i]  = 13'(int'(free_size[i]) - grant);
                    g.bytes = 13'(grant);
                end
                return g;
            end
        end
        return g;
    endfunction

    task automatic send_request(input t_kind k, input int off, input int sz);
        int     gap;
        t_grant g;
        gap = idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= IN_TDATA_W'({13'(sz), 12'(off)});
        do @(posedge i_clk); while (!s_axis_tready);
        g = apply_request(k, 12'(off), 13'(sz));
        pending_grants.push_back(g);
        if (k == KIND_ALLOC && g.status == STATUS_OK) begin
            live_segs.push_back('{size: g.bytes, start: g.offset});
        end
    endtask

    task automatic wait_grants_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_grants.size() != 0);
    endtask

    task automatic test_split_from_base();
        send_request(KIND_ALLOC, 0, 0);
        send_request(KIND_ALLOC, 4095, 1);
        send_request(KIND_ALLOC, 0, 17);
        send_request(KIND_ALLOC, 0, 4096);
        send_request(KIND_ALLOC, 0, 8191);
    endtask

    task automatic test_whole_and_empty();
        send_request(KIND_ALLOC, 0, 4020);
        send_request(KIND_ALLOC, 0, 1);
        send_request(KIND_ALLOC, 0, 0);
    endtask

    task automatic test_free_reinsert();
        send_request(KIND_FREE, 4095, 0);
        send_request(KIND_ALLOC, 0, 0);
        send_request(KIND_FREE, 64, 100);
        send_request(KIND_ALLOC, 0, 90);
        send_request(KIND_FREE, 0, 8191);
        send_request(KIND_ALLOC, 0, 8191);
        send_request(KIND_FREE, 4088, 200);
        send_request(KIND_ALLOC, 0, 100);
        send_request(KIND_ALLOC, 0, 4096);
    endtask

    task automatic test_table_full();
        repeat (18) send_request(KIND_FREE, $urandom_range(0, 4095), $urandom_range(16, 64));
        repeat (18) send_request(KIND_ALLOC, 0, $urandom_range(1, 64));
    endtask

    task automatic test_random_traffic();
        int   r;
        int   idx;
        t_seg s;
        for (int n = 0; n < 950; n++) begin
            if (n % 200 == 150) begin
                steady_flow <= 1'b1;
            end else if (n % 200 == 0) begin
                steady_flow <= 1'b0;
            end
            if (n % 250 == 125) begin
                wait_grants_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 50) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_request(KIND_ALLOC, $urandom_range(0, 4095), $urandom_range(1, 64));
                end else if (r < 90) begin
                    send_request(KIND_ALLOC, $urandom_range(0, 4095), $urandom_range(65, 512));
                end else if (r < 98) begin
                    send_request(KIND_ALLOC, $urandom_range(0, 4095), $urandom_range(513, 4096));
                end else begin
                    send_request(KIND_ALLOC, $urandom_range(0, 4095),
                                 ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(4097, 8191));
                end
            end else if (r < 85 && live_segs.size() > 0) begin
                idx = $urandom_range(0, live_segs.size() - 1);
                s   = live_segs[idx];
                live_segs.delete(idx);
                send_request(KIND_FREE, s.start, s.size);
            end else if ($urandom_range(0, 9) < 8) begin
                send_request(KIND_FREE, $urandom_range(0, 4095), $urandom_range(0, 300));
            end else begin
                send_request(KIND_FREE, $urandom_range(0, 4095), $urandom_range(0, 8191));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= idle_cycles();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result: status %0d", m_axis_tuser);
                n_fail++;
            end else begin
                got = pending_grants.pop_front();
                if (m_axis_tuser !== got.status) begin
                    $error("status: expected %0d, got %0d", got.status, m_axis_tuser);
                    n_fail++;
                end
                if (m_axis_tdata[START_W-1:0] !== got.offset) begin
                    $error("grant_offset: expected %0d, got %0d", got.offset,
                           m_axis_tdata[START_W-1:0]);
                    n_fail++;
                end
                if (m_axis_tdata[START_W +: SIZE_W] !== got.bytes) begin
                    $error("grant_bytes: expected %0d, got %0d", got.bytes,
                           m_axis_tdata[START_W +: SIZE_W]);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        n_fail        = 0;
        stall_left    = 0;
        free_count    = 1;
        free_start[0] = 12'(BASE_START);
        free_size[0]  = 13'(HEAP - BASE_START);
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_ALLOC;
        m_axis_tready <= 1'b0;
        steady_flow   <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_split_from_base();
        test_whole_and_empty();
        test_free_reinsert();
        test_table_full();
        test_random_traffic();
        wait_grants_drained();
        repeat (80) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_ram.sv
rtl/core/first_fit_segment_allocator.sv
rtl/core/ffsa_checker.sv
tb/tb.sv
